// ----- hdl/itas_pkg.sv -----
// shared types and constants of the tlv area scanner
`default_nettype none

package itas_pkg;

   localparam logic [2:0] HEADER_BYTES = 3'd4;

   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned CsrDataBits  = 32;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_WANTED_TYPE     = 3'd0,
      CSR_MATCH_ANY       = 3'd1,
      CSR_PROTECTED_ONLY  = 3'd2,
      CSR_PROTECTED_SIZE  = 3'd3,
      CSR_AREA_BASE       = 3'd4,
      CSR_INFO_MAGIC      = 3'd5,
      CSR_PROT_INFO_MAGIC = 3'd6
   } csr_index_type;

   localparam logic [15:0] INFO_MAGIC_RESET      = 16'h6907;
   localparam logic [15:0] PROT_INFO_MAGIC_RESET = 16'h6908;

   typedef enum logic [1:0] {
      STATUS_FOUND        = 2'd0,
      STATUS_NO_MORE      = 2'd1,
      STATUS_FORMAT_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] wanted_type;
      logic        match_any;
      logic        protected_only;
      logic [15:0] protected_size;
      logic [31:0] area_base;
      logic [15:0] info_magic;
      logic [15:0] prot_info_magic;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [31:0] entry_offset;
      logic [15:0] entry_length;
      logic [15:0] entry_type;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/itas_csr_regs.sv -----
// configuration register file of the tlv area scanner
`default_nettype none

module itas_csr_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [itas_pkg::CsrIndexBits-1:0]   csr_index,
   input  wire logic [itas_pkg::CsrDataBits-1:0]    csr_data,
   output itas_pkg::cfg_type                        cfg
);

   itas_pkg::cfg_type cfg_ff;
   itas_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (itas_pkg::csr_index_type'(csr_index))
            itas_pkg::CSR_WANTED_TYPE:     cfg_in.wanted_type     = csr_data[15:0];
            itas_pkg::CSR_MATCH_ANY:       cfg_in.match_any       = csr_data[0];
            itas_pkg::CSR_PROTECTED_ONLY:  cfg_in.protected_only  = csr_data[0];
            itas_pkg::CSR_PROTECTED_SIZE:  cfg_in.protected_size  = csr_data[15:0];
            itas_pkg::CSR_AREA_BASE:       cfg_in.area_base       = csr_data[31:0];
            itas_pkg::CSR_INFO_MAGIC:      cfg_in.info_magic      = csr_data[15:0];
            itas_pkg::CSR_PROT_INFO_MAGIC: cfg_in.prot_info_magic = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wanted_type     <= 16'd0;
         cfg_ff.match_any       <= 1'b1;
         cfg_ff.protected_only  <= 1'b0;
         cfg_ff.protected_size  <= 16'd0;
         cfg_ff.area_base       <= 32'd0;
         cfg_ff.info_magic      <= itas_pkg::INFO_MAGIC_RESET;
         cfg_ff.prot_info_magic <= itas_pkg::PROT_INFO_MAGIC_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/itas_scan_core.sv -----
// byte-wise trailer walker: header gathering, payload skipping, entry and status reporting
`default_nettype none

module itas_scan_core #(
   parameter int unsigned POSITION_BITS = 17
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire itas_pkg::cfg_type    cfg,
   input  wire logic                 beat_valid,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 start_req,
   output itas_pkg::result_type      result
);

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_FIRST,
      PH_PLAIN,
      PH_ENTRY,
      PH_PAYLOAD,
      PH_PENDING
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic                 fin;
      itas_pkg::status_type status;
   } bnd_type;

   phase_type                phase_ff, phase_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [23:0]              shift_ff, shift_in;
   logic [1:0]               count_ff, count_in;
   logic [15:0]              remaining_ff, remaining_in;
   logic [POSITION_BITS-1:0] area_end_ff, area_end_in;
   logic                     end_known_ff, end_known_in;

   // next step at an entry boundary
   function automatic bnd_type boundary(
      input logic [POSITION_BITS-1:0] pos,
      input logic                     known,
      input logic [POSITION_BITS-1:0] aend,
      input itas_pkg::cfg_type        c
   );
      bnd_type                  r;
      logic [POSITION_BITS-1:0] psz;
      psz      = POSITION_BITS'(c.protected_size);
      r.phase  = PH_WAIT;
      r.fin    = 1'b0;
      r.status = itas_pkg::STATUS_NO_MORE;
      if (c.protected_only && pos >= psz) begin
         r.fin = 1'b1;
      end else if (known) begin
         if (pos >= aend) begin
            r.fin = 1'b1;
         end else begin
            r.phase = PH_ENTRY;
         end
      end else if (pos == psz) begin
         r.phase = PH_PLAIN;
      end else if (pos < psz) begin
         r.phase = PH_ENTRY;
      end else begin
         r.fin    = 1'b1;
         r.status = itas_pkg::STATUS_FORMAT_ERROR;
      end
      return r;
   endfunction

   function automatic logic [POSITION_BITS-1:0] sat_add(
      input logic [POSITION_BITS-1:0] pos,
      input logic [2:0]               inc
   );
      logic [POSITION_BITS:0] sum;
      sum = {1'b0, pos} + (POSITION_BITS+1)'(inc);
      return sum[POSITION_BITS] ? {POSITION_BITS{1'b1}} : sum[POSITION_BITS-1:0];
   endfunction

   always_comb begin
      bnd_type                  bnd;
      logic                     done;
      logic                     do_bnd;
      logic                     match;
      logic [15:0]              lo;
      logic [15:0]              hi;
      logic [POSITION_BITS-1:0] at;
      logic [16:0]              plain_end;

      phase_in     = phase_ff;
      position_in  = position_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      area_end_in  = area_end_ff;
      end_known_in = end_known_ff;
      result       = '0;
      bnd          = '0;
      done         = 1'b0;
      do_bnd       = 1'b0;
      match        = 1'b0;
      lo           = shift_ff[15:0];
      hi           = {data_byte, shift_ff[23:16]};
      at           = position_ff;
      plain_end    = 17'd0;

      if (beat_valid) begin
         if (start_req) begin
            phase_in     = PH_FIRST;
            position_in  = '0;
            shift_in     = '0;
            count_in     = '0;
            remaining_in = '0;
            area_end_in  = '0;
            end_known_in = 1'b0;
         end

         // decision left over from a zero-length match
         if (phase_in == PH_PENDING) begin
            bnd      = boundary(position_in, end_known_in, area_end_in, cfg);
            shift_in = '0;
            count_in = '0;
            if (bnd.fin) begin
               phase_in      = PH_WAIT;
               result.valid  = 1'b1;
               result.status = bnd.status;
               done          = 1'b1;
            end else begin
               phase_in = bnd.phase;
            end
         end

         if (!done) begin
            case (phase_in)
               PH_PAYLOAD: begin
                  position_in  = sat_add(position_in, 3'd1);
                  remaining_in = remaining_in - 16'd1;
                  do_bnd       = (remaining_in == 16'd0);
               end
               PH_FIRST, PH_PLAIN, PH_ENTRY: begin
                  if (count_in != 2'd3) begin
                     shift_in[{count_in, 3'b000} +: 8] = data_byte;
                     count_in = count_in + 2'd1;
                  end else begin
                     lo          = shift_in[15:0];
                     hi          = {data_byte, shift_in[23:16]};
                     shift_in    = '0;
                     count_in    = '0;
                     at          = position_in;
                     position_in = sat_add(position_in, itas_pkg::HEADER_BYTES);
                     case (phase_in)
                        PH_FIRST: begin
                           if (lo == cfg.prot_info_magic) begin
                              if (hi != cfg.protected_size ||
                                  cfg.protected_size < 16'(itas_pkg::HEADER_BYTES)) begin
                                 phase_in      = PH_WAIT;
                                 result.valid  = 1'b1;
                                 result.status = itas_pkg::STATUS_FORMAT_ERROR;
                              end else begin
                                 do_bnd = 1'b1;
                              end
                           end else if (cfg.protected_size != 16'd0 ||
                                        lo != cfg.info_magic) begin
                              phase_in      = PH_WAIT;
                              result.valid  = 1'b1;
                              result.status = itas_pkg::STATUS_FORMAT_ERROR;
                           end else begin
                              area_end_in  = POSITION_BITS'(hi);
                              end_known_in = 1'b1;
                              do_bnd       = 1'b1;
                           end
                        end
                        PH_PLAIN: begin
                           if (lo != cfg.info_magic) begin
                              phase_in      = PH_WAIT;
                              result.valid  = 1'b1;
                              result.status = itas_pkg::STATUS_FORMAT_ERROR;
                           end else begin
                              plain_end    = {1'b0, cfg.protected_size} + {1'b0, hi};
                              area_end_in  = POSITION_BITS'(plain_end);
                              end_known_in = 1'b1;
                              do_bnd       = 1'b1;
                           end
                        end
                        default: begin
                           match = cfg.match_any || (lo == cfg.wanted_type);
                           if (match) begin
                              result.valid        = 1'b1;
                              result.status       = itas_pkg::STATUS_FOUND;
                              result.entry_offset = cfg.area_base + 32'(at)
                                                    + 32'(itas_pkg::HEADER_BYTES);
                              result.entry_length = hi;
                              result.entry_type   = lo;
                           end
                           if (hi != 16'd0) begin
                              remaining_in = hi;
                              phase_in     = PH_PAYLOAD;
                           end else if (match) begin
                              // end check waits for the next beat
                              phase_in = PH_PENDING;
                           end else begin
                              do_bnd = 1'b1;
                           end
                        end
                     endcase
                  end
               end
               default: ;
            endcase

            if (do_bnd) begin
               bnd      = boundary(position_in, end_known_in, area_end_in, cfg);
               shift_in = '0;
               count_in = '0;
               if (bnd.fin) begin
                  phase_in      = PH_WAIT;
                  result.valid  = 1'b1;
                  result.status = bnd.status;
               end else begin
                  phase_in = bnd.phase;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         position_ff  <= '0;
         shift_ff     <= '0;
         count_ff     <= '0;
         remaining_ff <= '0;
         area_end_ff  <= '0;
         end_known_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         area_end_ff  <= area_end_in;
         end_known_ff <= end_known_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/image_tlv_area_scanner.sv -----
// Boot image TLV trailer scanner. One trailer byte is taken per beat on req_ and the
// block accepts a byte in every cycle, one byte per clock sustained, unless a full
// result register is not being drained: each byte passes through a single
// compare-and-count step into the scan state and, when it completes an entry header
// or ends the scan, into the result register on rsp_. That register lets the next byte
// in while a result still waits; req_tready drops only when it is full and not being
// drained. A result appears in the cycle after the byte that caused it. No clearing pass is needed after reset.
`default_nettype none

module image_tlv_area_scanner #(
   parameter int unsigned POSITION_BITS = 17
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // trailer bytes
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // data_byte
   input  wire logic                               req_tuser,  // start_req
   // scan results
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // entry_offset[31:0], entry_length[47:32], entry_type[63:48]
   output logic [63:0]                             rsp_tdata,
   output logic [1:0]                              rsp_tuser,  // status
   // configuration writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [itas_pkg::CsrIndexBits-1:0]  csr_index,
   input  wire logic [itas_pkg::CsrDataBits-1:0]   csr_data
);

   itas_pkg::cfg_type    cfg;
   itas_pkg::result_type result;
   itas_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_beat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   itas_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   itas_scan_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .beat_valid (req_beat),
      .data_byte  (req_tdata),
      .start_req  (req_tuser),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat && result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.entry_type, rsp_ff.entry_length, rsp_ff.entry_offset};
   assign rsp_tuser  = rsp_ff.status;

   // only a found entry carries offset, length and type
   a_fields_zero_unless_found: assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != itas_pkg::STATUS_FOUND |-> rsp_tdata == 64'd0
   ) else $error("non-entry result carries entry fields");

   a_status_legal: assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == itas_pkg::STATUS_FOUND ||
                     rsp_tuser == itas_pkg::STATUS_NO_MORE ||
                     rsp_tuser == itas_pkg::STATUS_FORMAT_ERROR
   ) else $error("illegal result status");

   // a new result is always caused by a byte taken the cycle before
   a_result_from_beat: assert property (
      @(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(req_tvalid && req_tready)
   ) else $error("result appeared without an accepted beat");

endmodule

`default_nettype wire
